// ===== sv/tli_pkg.sv =====
package tli_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_LOG_X    = 2'd1;
    localparam logic [1:0] REG_LOG_Y    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_NONE       = 2'd1;
    localparam logic [1:0] ST_BAD_TARGET = 2'd2;

    // Fixed-point constants for log10 and 10^v
    localparam logic [26:0] LOG10_2_Q28 = 27'd80807124;
    localparam logic [29:0] LOG2_10_Q28 = 30'd891723283;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;

    // 15 * 2^44 and 17 * 2^44: saturation limits of log2 of the antilog result
    localparam logic signed [63:0] EXP_HI  = 64'sd263882790666240;
    localparam logic signed [63:0] EXP_OFS = 64'sd299067162755072;

    // One table point after classification
    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               valid;
        logic               last_point;
    } t_item;

    // Configuration seen by the back end
    typedef struct packed {
        logic signed [31:0] target_x;
        logic               log_x_mode;
        logic               log_y_mode;
    } t_cfg;

endpackage

// ===== sv/tli_front.sv =====
module tli_front #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [31:0]   i_x_value,
    input  logic signed [31:0]   i_y_value,
    input  logic                 i_x_missing,
    input  logic                 i_y_missing,
    input  logic                 i_last_point,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tli_pkg::t_item       o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tli_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_do_push;
    logic           w_do_pop;
    tli_pkg::t_item w_in;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_item    = r_mem[r_rd_ptr];

    // Classify: a point is usable only when neither coordinate is null
    always_comb begin
        w_in.x_value    = i_x_value;
        w_in.y_value    = i_y_value;
        w_in.valid      = !i_x_missing && !i_y_missing;
        w_in.last_point = i_last_point;
    end

    // Store accepted points
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= w_in;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/tli_log10.sv =====
module tli_log10 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_arg,
    output logic               o_done,
    output logic signed [31:0] o_result
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_SQ   = 4'b0100,
        L_MUL  = 4'b1000
    } t_lstate;

    localparam logic [26:0] LOG10_2_Q28_W = tli_pkg::LOG10_2_Q28;

    t_lstate            r_state;
    logic [32:0]        r_m;
    logic [4:0]         r_p;
    logic [29:0]        r_frac;
    logic [4:0]         r_i;
    logic               r_done;
    logic signed [31:0] r_result;

    logic [63:0]        w_sq;
    logic [32:0]        w_t;
    logic signed [5:0]  w_p_off;
    logic signed [36:0] w_l30;
    logic [35:0]        w_mag;
    logic [62:0]        w_prod;
    logic [63:0]        w_rnd;
    logic [31:0]        w_abs;

    // Squaring step and final scaling by log10(2)
    always_comb begin
        w_sq    = r_m[31:0] * r_m[31:0];
        w_t     = w_sq[63:31];
        w_p_off = $signed({1'b0, r_p}) - 6'sd16;
        w_l30   = $signed({w_p_off[5], w_p_off, 30'd0}) + $signed({7'd0, r_frac});
        w_mag   = w_l30[36] ? 36'(-w_l30) : w_l30[35:0];
        w_prod  = w_mag * LOG10_2_Q28_W;
        w_rnd   = (64'(w_prod) + (64'd1 << 41)) >> 42;
        w_abs   = w_rnd[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_m     <= {1'b0, i_arg};
                        r_p     <= 5'd31;
                        r_frac  <= '0;
                        r_state <= L_NORM;
                    end
                end
                // Shift up to the leading one, one bit a cycle
                L_NORM: begin
                    if (!r_m[31]) begin
                        r_m <= {r_m[31:0], 1'b0};
                        r_p <= r_p - 1'b1;
                    end else begin
                        r_i     <= '0;
                        r_state <= L_SQ;
                    end
                end
                // One fraction bit of log2 per squaring
                L_SQ: begin
                    if (w_t[32]) begin
                        r_m                 <= {1'b0, w_t[32:1]};
                        r_frac[5'd29 - r_i] <= 1'b1;
                    end else begin
                        r_m <= w_t;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 5'd29) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_result <= w_l30[36] ? -$signed(w_abs) : $signed(w_abs);
                    r_done   <= 1'b1;
                    r_state  <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== sv/tli_div.sv =====
module tli_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dvs;
    logic [32:0] w_rem_sh;
    logic        w_ge;

    // One quotient bit per cycle, restoring form
    assign w_rem_sh = {r_rem[31:0], r_quo[63]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_rem  <= '0;
                    r_quo  <= i_dividend;
                    r_dvs  <= i_divisor;
                end
            end else begin
                r_rem <= w_ge ? w_rem_sh - {1'b0, r_dvs} : w_rem_sh;
                r_quo <= {r_quo[62:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/tli_back.sv =====
module tli_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tli_pkg::t_cfg        i_cfg,
    input  logic                 i_item_empty,
    input  tli_pkg::t_item       i_item,
    output logic                 o_item_pop,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_out_value,
    output logic [1:0]           o_out_status,
    input  logic                 i_out_pop
);

    typedef enum logic [20:0] {
        S_IDLE = 21'h000001,
        S_LTX  = 21'h000002,
        S_WTX  = 21'h000004,
        S_LX   = 21'h000008,
        S_WX   = 21'h000010,
        S_LY   = 21'h000020,
        S_WY   = 21'h000040,
        S_CMP  = 21'h000080,
        S_MUL  = 21'h000100,
        S_DIV  = 21'h000200,
        S_WDIV = 21'h000400,
        S_E0   = 21'h000800,
        S_E1   = 21'h001000,
        S_E2   = 21'h002000,
        S_E3   = 21'h004000,
        S_E4   = 21'h008000,
        S_WE4  = 21'h010000,
        S_E5   = 21'h020000,
        S_FIN  = 21'h040000,
        S_UPD  = 21'h080000,
        S_OUT  = 21'h100000
    } t_state;

    t_state             r_state;
    // current point
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic               r_valid;
    logic               r_last;
    logic signed [31:0] r_tx;
    logic               r_tok;
    // table state
    logic signed [31:0] r_prev_x;
    logic signed [31:0] r_prev_y;
    logic               r_prev_valid;
    logic               r_found;
    logic signed [31:0] r_held;
    // interpolation datapath
    logic [31:0]        r_num;
    logic [31:0]        r_ady;
    logic               r_dneg;
    logic [31:0]        r_den;
    logic [63:0]        r_prod;
    logic signed [33:0] r_acc;
    // antilog datapath
    logic signed [63:0] r_w;
    logic [48:0]        r_wo;
    logic [29:0]        r_yv;
    logic [30:0]        r_term;
    logic [32:0]        r_sum;
    logic [3:0]         r_k;
    // unit handshakes
    logic               r_lstart;
    logic [31:0]        r_larg;
    logic               r_dstart;
    // result register
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [1:0]         r_out_status;

    logic               w_ldone;
    logic signed [31:0] w_lres;
    logic               w_ddone;
    logic [63:0]        w_quo;

    logic signed [31:0] w_xz;
    logic signed [31:0] w_yz;
    logic               w_hit;
    logic signed [32:0] w_den;
    logic signed [32:0] w_num;
    logic signed [32:0] w_dy;
    logic signed [33:0] w_q;
    logic [59:0]        w_yprod;
    logic [60:0]        w_tprod;
    logic [4:0]         w_top;
    logic [4:0]         w_sh;
    logic [33:0]        w_res;

    tli_log10 u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_lstart),
        .i_arg    (r_larg),
        .o_done   (w_ldone),
        .o_result (w_lres)
    );

    tli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (w_ddone),
        .o_quotient (w_quo)
    );

    // Bracket test and interval differences
    always_comb begin
        w_xz    = r_valid ? r_x : 32'sd0;
        w_yz    = r_valid ? r_y : 32'sd0;
        w_hit   = r_tok && !r_found && r_prev_valid && r_valid &&
                  (r_prev_x <= r_tx) && (w_xz >= r_tx);
        w_den   = 33'(w_xz) - 33'(r_prev_x);
        w_num   = 33'(r_tx) - 33'(r_prev_x);
        w_dy    = 33'(w_yz) - 33'(r_prev_y);
        w_q     = $signed({1'b0, w_quo[32:0]});
        w_yprod = r_wo[43:14] * tli_pkg::LN2_Q30;
        w_tprod = r_term * r_yv;
        w_top   = r_wo[48:44];
        w_sh    = 5'd31 - w_top;
        if (w_top == 5'd31) begin
            w_res = 34'(r_sum);
        end else begin
            w_res = (34'(r_sum) + (34'd1 << (w_sh - 5'd1))) >> w_sh;
        end
    end

    assign o_item_pop = (r_state == S_IDLE) && !i_item_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_valid <= 1'b0;
            r_found      <= 1'b0;
            r_held       <= '0;
            r_lstart     <= 1'b0;
            r_dstart     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_lstart <= 1'b0;
            r_dstart <= 1'b0;
            if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // Take the next point from the queue
                S_IDLE: begin
                    if (!i_item_empty) begin
                        r_x     <= i_item.x_value;
                        r_y     <= i_item.y_value;
                        r_valid <= i_item.valid;
                        r_last  <= i_item.last_point;
                        r_tx    <= i_cfg.target_x;
                        r_tok   <= 1'b1;
                        r_state <= S_LTX;
                    end
                end
                // Target in log space
                S_LTX: begin
                    if (i_cfg.log_x_mode) begin
                        if (r_tx > 32'sd0) begin
                            r_larg   <= r_tx;
                            r_lstart <= 1'b1;
                            r_state  <= S_WTX;
                        end else begin
                            r_tok   <= 1'b0;
                            r_state <= S_LX;
                        end
                    end else begin
                        r_state <= S_LX;
                    end
                end
                S_WTX: begin
                    if (w_ldone) begin
                        r_tx    <= w_lres;
                        r_state <= S_LX;
                    end
                end
                // x in log space; not positive counts as null
                S_LX: begin
                    if (i_cfg.log_x_mode) begin
                        if (r_valid && r_x > 32'sd0) begin
                            r_larg   <= r_x;
                            r_lstart <= 1'b1;
                            r_state  <= S_WX;
                        end else begin
                            r_valid <= 1'b0;
                            r_state <= S_LY;
                        end
                    end else begin
                        r_state <= S_LY;
                    end
                end
                S_WX: begin
                    if (w_ldone) begin
                        r_x     <= w_lres;
                        r_state <= S_LY;
                    end
                end
                // y in log space
                S_LY: begin
                    if (i_cfg.log_y_mode) begin
                        if (r_valid && r_y > 32'sd0) begin
                            r_larg   <= r_y;
                            r_lstart <= 1'b1;
                            r_state  <= S_WY;
                        end else begin
                            r_valid <= 1'b0;
                            r_state <= S_CMP;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_WY: begin
                    if (w_ldone) begin
                        r_y     <= w_lres;
                        r_state <= S_CMP;
                    end
                end
                // Zero null points and test the bracket
                S_CMP: begin
                    r_x   <= w_xz;
                    r_y   <= w_yz;
                    r_num <= w_num[31:0];
                    r_ady <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
                    r_dneg <= w_dy[32];
                    r_den <= w_den[31:0];
                    if (!w_hit) begin
                        r_state <= S_UPD;
                    end else if (w_den == 33'sd0) begin
                        // equal x at both ends: take the first point's y
                        r_acc   <= 34'(r_prev_y);
                        r_state <= i_cfg.log_y_mode ? S_E0 : S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_num * r_ady;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_WDIV;
                end
                S_WDIV: begin
                    if (w_ddone) begin
                        r_acc   <= r_dneg ? 34'(r_prev_y) - w_q : 34'(r_prev_y) + w_q;
                        r_state <= i_cfg.log_y_mode ? S_E0 : S_FIN;
                    end
                end
                // Antilog: log2 of the result
                S_E0: begin
                    r_w     <= 64'(r_acc * $signed({1'b0, tli_pkg::LOG2_10_Q28}));
                    r_state <= S_E1;
                end
                S_E1: begin
                    if (r_w >= tli_pkg::EXP_HI) begin
                        r_held  <= 32'sh7FFFFFFF;
                        r_found <= 1'b1;
                        r_state <= S_UPD;
                    end else if (r_w < -tli_pkg::EXP_OFS) begin
                        r_held  <= '0;
                        r_found <= 1'b1;
                        r_state <= S_UPD;
                    end else begin
                        r_wo    <= 49'(r_w + tli_pkg::EXP_OFS);
                        r_state <= S_E2;
                    end
                end
                S_E2: begin
                    r_yv    <= w_yprod[59:30];
                    r_term  <= 31'd1 << 30;
                    r_sum   <= 33'd1 << 30;
                    r_k     <= 4'd1;
                    r_state <= S_E3;
                end
                // Series term: term * y, then divide by k
                S_E3: begin
                    r_prod  <= 64'(w_tprod[60:30]);
                    r_den   <= 32'(r_k);
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_WE4;
                end
                S_WE4: begin
                    if (w_ddone) begin
                        r_term <= w_quo[30:0];
                        r_sum  <= r_sum + 33'(w_quo[30:0]);
                        r_k    <= r_k + 1'b1;
                        r_state <= (r_k == 4'd14) ? S_E5 : S_E3;
                    end
                end
                // Scale by the integer power and saturate
                S_E5: begin
                    r_held  <= (w_res > 34'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(w_res[31:0]);
                    r_found <= 1'b1;
                    r_state <= S_UPD;
                end
                S_FIN: begin
                    r_held  <= r_acc[31:0];
                    r_found <= 1'b1;
                    r_state <= S_UPD;
                end
                // Keep this point as the previous one
                S_UPD: begin
                    r_prev_x     <= r_x;
                    r_prev_y     <= r_y;
                    r_prev_valid <= r_valid;
                    r_state      <= r_last ? S_OUT : S_IDLE;
                end
                // Emit the result and clear table state
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        if (!r_tok) begin
                            r_out_value  <= '0;
                            r_out_status <= tli_pkg::ST_BAD_TARGET;
                        end else if (r_found) begin
                            r_out_value  <= r_held;
                            r_out_status <= tli_pkg::ST_FOUND;
                        end else begin
                            r_out_value  <= '0;
                            r_out_status <= tli_pkg::ST_NONE;
                        end
                        r_prev_x     <= '0;
                        r_prev_y     <= '0;
                        r_prev_valid <= 1'b0;
                        r_found      <= 1'b0;
                        r_held       <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;

endmodule

// ===== sv/table_linear_interpolator.sv =====
// Piecewise-linear table interpolator, signed Q16.16. Table points are pushed
// one per transaction; the first adjacent pair of usable points that brackets
// target_x is interpolated, optionally in log10 of x and/or y, and one result
// with a status comes out for the point marked last_point. A small input queue
// decouples the push side from a serial back end, which handles one point at a
// time. Each log10 taken is a leading-one search plus 30 squarings; the point
// that closes the bracket (distinct x) goes through a multiply and the 64-step
// divider, and in log y mode the antilog on that point adds 14 divider passes.
module table_linear_interpolator #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // points
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic               i_x_missing,
    input  logic               i_y_missing,
    input  logic               i_last_point,
    // results
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);

    logic signed [31:0] r_target_x;
    logic               r_log_x;
    logic               r_log_y;
    logic               w_wr;
    logic [1:0]         w_idx;
    tli_pkg::t_cfg      w_cfg;
    tli_pkg::t_item     w_item;
    logic               w_item_empty;
    logic               w_item_pop;
    logic               w_out_valid;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= '0;
            r_log_x    <= 1'b0;
            r_log_y    <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                tli_pkg::REG_TARGET_X: r_target_x <= pwdata;
                tli_pkg::REG_LOG_X:    r_log_x    <= pwdata[0];
                tli_pkg::REG_LOG_Y:    r_log_y    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (w_idx)
            tli_pkg::REG_TARGET_X: prdata = r_target_x;
            tli_pkg::REG_LOG_X:    prdata = {31'd0, r_log_x};
            tli_pkg::REG_LOG_Y:    prdata = {31'd0, r_log_y};
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.target_x   = r_target_x;
        w_cfg.log_x_mode = r_log_x;
        w_cfg.log_y_mode = r_log_y;
    end

    tli_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_x_missing  (i_x_missing),
        .i_y_missing  (i_y_missing),
        .i_last_point (i_last_point),
        .i_pop        (w_item_pop),
        .o_empty      (w_item_empty),
        .o_item       (w_item)
    );

    tli_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_empty (w_item_empty),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_out_valid  (w_out_valid),
        .o_out_value  (o_result_value),
        .o_out_status (o_status),
        .i_out_pop    (pop)
    );

    assign empty = !w_out_valid;

    // A result that is not found carries a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != tli_pkg::ST_FOUND) |-> (o_result_value == 32'sd0))
        else $error("non-found result with nonzero value");

    // Status is always a defined code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == tli_pkg::ST_FOUND || o_status == tli_pkg::ST_NONE ||
                    o_status == tli_pkg::ST_BAD_TARGET))
        else $error("undefined status code");

    // Reset leaves no result waiting
    assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

endmodule

// ===== tb/tb_table_linear_interpolator.sv =====
module tb_table_linear_interpolator;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               push;
    logic               full;
    logic signed [31:0] i_x_value;
    logic signed [31:0] i_y_value;
    logic               i_x_missing;
    logic               i_y_missing;
    logic               i_last_point;
    logic               empty;
    logic               pop;
    logic signed [31:0] o_result_value;
    logic [1:0]         o_status;

    table_linear_interpolator dut (.*);

    // Index past the register list
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Register shadow and interpolation state of the predictor
    logic signed [31:0] cfg_target;
    logic               cfg_log_x;
    logic               cfg_log_y;
    longint             pt_prev_x;
    longint             pt_prev_y;
    bit                 pt_prev_ok;
    bit                 pt_found;
    longint             pt_held;

    // Expected results, oldest first
    logic signed [31:0] want_value[$];
    logic [1:0]         want_status[$];
    int                 n_fail;
    int                 n_pushed;

    // Typed expectation for the next last point, applied at acceptance
    bit                 ovr_on;
    logic signed [31:0] ovr_value;
    logic [1:0]         ovr_status;

    // Directed table: one point per row, typed result where obvious
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 xm;
        bit                 ym;
        bit                 last;
        bit                 typed;
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_row;

    localparam int N_ROWS = 16;
    t_row rows[N_ROWS] = '{
        '{32'sd5, 32'sd9, 0, 0, 1, 1, 32'sd0, tli_pkg::ST_NONE},
        '{-32'sd65536, 32'sd100, 0, 0, 0, 0, 0, 0},
        '{32'sd65536, 32'sd300, 0, 0, 1, 1, 32'sd200, tli_pkg::ST_FOUND},
        '{32'sd0, 32'sd7, 0, 0, 0, 0, 0, 0},
        '{32'sd0, 32'sd9, 0, 0, 1, 1, 32'sd7, tli_pkg::ST_FOUND},
        '{32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
        '{32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1, 1, 32'sd0, tli_pkg::ST_FOUND},
        '{-32'sd10, 32'sd1, 1, 0, 0, 0, 0, 0},
        '{32'sd10, 32'sd2, 0, 0, 1, 1, 32'sd0, tli_pkg::ST_NONE},
        '{-32'sd10, 32'sd1, 0, 1, 0, 0, 0, 0},
        '{32'sd10, 32'sd2, 0, 0, 1, 1, 32'sd0, tli_pkg::ST_NONE},
        '{32'sd10, 32'sd1, 0, 0, 0, 0, 0, 0},
        '{32'sd20, 32'sd2, 0, 0, 1, 1, 32'sd0, tli_pkg::ST_NONE},
        '{-32'sd300, 32'sd1000, 0, 0, 0, 0, 0, 0},
        '{-32'sd100, -32'sd5000, 0, 0, 0, 0, 0, 0},
        '{32'sd700, 32'sd77, 1, 1, 1, 0, 0, 0}
    };

    // log10 of a positive Q16.16 value, Q16.16 rounded to nearest
    function automatic longint log10_q16(input logic [31:0] u);
        int         msb;
        bit [63:0]  m;
        bit [63:0]  frac;
        longint     l30;
        bit [63:0]  mag;
        msb = 31;
        while (msb > 0 && u[msb] == 1'b0) msb--;
        m = 64'(u) << (31 - msb);
        frac = 0;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[29 - i] = 1'b1;
            end
        end
        l30 = longint'(msb - 16) * (64'sd1 <<< 30) + longint'(frac);
        mag = (l30 < 0) ? bit'(0) - l30 : l30;
        mag = (mag * 64'(tli_pkg::LOG10_2_Q28) + (64'd1 << 41)) >> 42;
        return (l30 < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // 10^v for a Q16.16 value, saturated to the positive Q16.16 range
    function automatic longint exp10_q16(input longint v);
        longint    w;
        bit [63:0] wo;
        int        n;
        int        sh;
        bit [63:0] f30;
        bit [63:0] yv;
        bit [63:0] term;
        bit [63:0] acc;
        bit [63:0] res;
        w = v * longint'(tli_pkg::LOG2_10_Q28);
        if (w >= tli_pkg::EXP_HI) return 64'h7fff_ffff;
        if (w < -tli_pkg::EXP_OFS) return 0;
        wo = w + tli_pkg::EXP_OFS;
        n = int'(wo >> 44) - 17;
        f30 = (wo & ((64'd1 << 44) - 1)) >> 14;
        yv = (f30 * 64'(tli_pkg::LN2_Q30)) >> 30;
        term = 64'd1 << 30;
        acc = term;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * yv) >> 30) / k;
            acc += term;
        end
        if (n >= 14) begin
            res = acc;
        end else begin
            sh = 14 - n;
            res = (acc + (64'd1 << (sh - 1))) >> sh;
        end
        if (res > 64'h7fff_ffff) res = 64'h7fff_ffff;
        return longint'(res);
    endfunction

    // Advance the interpolation state by one accepted point
    task automatic track_point(input logic signed [31:0] xv, input logic signed [31:0] yv,
                               input bit xm, input bit ym, input bit last);
        longint    x;
        longint    y;
        longint    tx;
        longint    den;
        longint    dy;
        longint    r;
        bit [63:0] q;
        bit        ok;
        bit        tgt_ok;
        x = xv;
        y = yv;
        tx = cfg_target;
        ok = !xm && !ym;
        tgt_ok = 1;
        if (cfg_log_x) begin
            if (tx > 0) tx = log10_q16(cfg_target);
            else tgt_ok = 0;
            if (ok && x > 0) x = log10_q16(xv);
            else ok = 0;
        end
        if (cfg_log_y) begin
            if (ok && y > 0) y = log10_q16(yv);
            else ok = 0;
        end
        if (!ok) begin
            x = 0;
            y = 0;
        end
        if (tgt_ok && !pt_found && pt_prev_ok && ok && pt_prev_x <= tx && x >= tx) begin
            den = x - pt_prev_x;
            if (den == 0) begin
                r = pt_prev_y;
            end else begin
                dy = y - pt_prev_y;
                q = ($unsigned(tx - pt_prev_x) * $unsigned(dy < 0 ? -dy : dy)) /
                    $unsigned(den);
                r = (dy < 0) ? pt_prev_y - longint'(q) : pt_prev_y + longint'(q);
            end
            if (cfg_log_y) r = exp10_q16(r);
            pt_held = r;
            pt_found = 1;
        end
        pt_prev_x = x;
        pt_prev_y = y;
        pt_prev_ok = ok;
        if (last) begin
            if (!tgt_ok) begin
                want_value.push_back(0);
                want_status.push_back(tli_pkg::ST_BAD_TARGET);
            end else if (pt_found) begin
                want_value.push_back(pt_held[31:0]);
                want_status.push_back(tli_pkg::ST_FOUND);
            end else begin
                want_value.push_back(0);
                want_status.push_back(tli_pkg::ST_NONE);
            end
            pt_prev_x = 0;
            pt_prev_y = 0;
            pt_prev_ok = 0;
            pt_found = 0;
            pt_held = 0;
        end
    endtask

    // Push one point; hold until accepted, then idle for a random gap
    task automatic send_point(input logic signed [31:0] xv, input logic signed [31:0] yv,
                              input bit xm, input bit ym, input bit last);
        int gap;
        push = 1;
        i_x_value = xv;
        i_y_value = yv;
        i_x_missing = xm;
        i_y_missing = ym;
        i_last_point = last;
        do @(posedge i_clk); while (full);
        track_point(xv, yv, xm, ym, last);
        // Typed expectation replaces the predicted one before it can be popped
        if (ovr_on && last) begin
            want_value[want_value.size() - 1] = ovr_value;
            want_status[want_status.size() - 1] = ovr_status;
        end
        ovr_on = 0;
        n_pushed++;
        @(negedge i_clk);
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) :
              ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            push = 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Wait for all results, let the back end settle, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        while (want_value.size() > 0) @(negedge i_clk);
        repeat (1100) @(negedge i_clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        case (idx)
            tli_pkg::REG_TARGET_X: cfg_target = val;
            tli_pkg::REG_LOG_X:    cfg_log_x = val[0];
            tli_pkg::REG_LOG_Y:    cfg_log_y = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    // One table: mostly sorted points around the target, some noise
    task automatic send_table();
        int        npts;
        longint    lo;
        longint    hi;
        longint    xs[8];
        longint    tmp;
        bit        noise;
        logic [31:0] yv;
        npts = $urandom_range(1, 6);
        noise = ($urandom_range(0, 9) == 0);
        if (cfg_log_x) begin
            lo = 1;
            hi = (cfg_target > 0) ? longint'(cfg_target) * 3 : 64'd1 << 20;
        end else begin
            tmp = $urandom_range(1, 1 << 22);
            lo = longint'(cfg_target) - tmp;
            hi = longint'(cfg_target) + tmp;
        end
        if (lo < -64'sd2147483648) lo = -64'sd2147483648;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        for (int i = 0; i < npts; i++) xs[i] = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
        for (int i = 1; i < npts; i++)
            for (int j = i; j > 0 && xs[j - 1] > xs[j]; j--) begin
                tmp = xs[j];
                xs[j] = xs[j - 1];
                xs[j - 1] = tmp;
            end
        for (int i = 0; i < npts; i++) begin
            if (noise) begin
                send_point($urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                           i == npts - 1);
            end else begin
                yv = cfg_log_y ? $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 16)
                               : $urandom;
                send_point(xs[i][31:0], yv, $urandom_range(0, 15) == 0,
                           $urandom_range(0, 15) == 0, i == npts - 1);
            end
        end
    endtask

    // Clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random pop with occasional long stalls, check each transaction
    initial begin
        int   stall;
        longint diff;
        longint tol;
        pop = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 30) == 0) begin
                pop = 0;
                stall = $urandom_range(10, 150);
                repeat (stall) @(negedge i_clk);
            end
            pop = ($urandom_range(0, 3) != 0);
            @(posedge i_clk);
            if (pop && !empty) begin
                if (want_value.size() == 0) begin
                    $error("result with nothing expected: value %0d status %0d",
                           o_result_value, o_status);
                    n_fail++;
                end else begin
                    diff = longint'(o_result_value) - longint'(want_value[0]);
                    if (diff < 0) diff = -diff;
                    // log modes carry a small rounding tolerance, amplified by 10^v
                    tol = (cfg_log_x || cfg_log_y) ?
                          2 + ((want_value[0] < 0 ? -longint'(want_value[0])
                                                  : longint'(want_value[0])) >> 10) : 0;
                    if (diff > tol) begin
                        $error("result_value: expected %0d, got %0d", want_value[0],
                               o_result_value);
                        n_fail++;
                    end
                    if (o_status !== want_status[0]) begin
                        $error("status: expected %0d, got %0d", want_status[0], o_status);
                        n_fail++;
                    end
                    void'(want_value.pop_front());
                    void'(want_status.pop_front());
                end
            end
        end
    end

    // Timeout
    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus
    initial begin
        logic signed [31:0] phase_target;
        n_fail = 0;
        n_pushed = 0;
        ovr_on = 0;
        ovr_value = 0;
        ovr_status = 0;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        push = 0;
        i_x_value = 0;
        i_y_value = 0;
        i_x_missing = 0;
        i_y_missing = 0;
        i_last_point = 0;
        cfg_target = 0;
        cfg_log_x = 0;
        cfg_log_y = 0;
        pt_prev_x = 0;
        pt_prev_y = 0;
        pt_prev_ok = 0;
        pt_found = 0;
        pt_held = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed rows at reset configuration
        for (int i = 0; i < N_ROWS; i++) begin
            ovr_on = rows[i].typed;
            ovr_value = rows[i].value;
            ovr_status = rows[i].status;
            send_point(rows[i].x, rows[i].y, rows[i].xm, rows[i].ym, rows[i].last);
        end
        push = 0;

        // Non-positive target in log x mode, and a write to an unused index
        write_reg(tli_pkg::REG_LOG_X, 1);
        write_reg(REG_SPARE, 32'hffff_ffff);
        send_point(32'sd65536, 32'sd65536, 0, 0, 0);
        ovr_on = 1;
        ovr_value = 0;
        ovr_status = tli_pkg::ST_BAD_TARGET;
        send_point(32'sd131072, 32'sd65536, 0, 0, 1);
        push = 0;

        // Random phases over several settings, extremes among them
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: phase_target = 32'h8000_0000;
                1: phase_target = 32'h7fff_ffff;
                2: phase_target = 0;
                3: phase_target = -$urandom_range(1, 1 << 20);
                default: phase_target = $urandom_range(1 << 12, 1 << 26);
            endcase
            write_reg(tli_pkg::REG_TARGET_X, phase_target);
            write_reg(tli_pkg::REG_LOG_X, ph inside {4, 6, 8});
            write_reg(tli_pkg::REG_LOG_Y, ph inside {5, 6});
            while (n_pushed < 30 + 75 * (ph + 1)) send_table();
            push = 0;
        end

        while (want_value.size() > 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);
        if (want_value.size() > 0) begin
            $error("%0d results never arrived", want_value.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tli_pkg.sv
sv/tli_front.sv
sv/tli_log10.sv
sv/tli_div.sv
sv/tli_back.sv
sv/table_linear_interpolator.sv
tb/tb_table_linear_interpolator.sv
